// File: design/cdk_pkg.sv
// types and constants shared by the color distance key mask block
// no dependencies
`timescale 1ns / 1ps

package cdk_pkg;

  localparam int CH_W     = 8;
  localparam int DIFF_W   = 9;
  localparam int SQ_W     = 16;
  localparam int D2_W     = 18;
  localparam int FRAC_W   = 16;
  localparam int RAD_W    = D2_W + FRAC_W;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int RES_W    = RAD_W + 1;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int TOL_W    = 13;
  localparam int SCALE_W  = 9;
  localparam int LIM_W    = 22;
  localparam int DIST_W   = ROOT_W + 4;
  localparam int NUM_W    = LIM_W + 8;
  localparam int Q_W      = 8;
  localparam int DIV_STAGES = Q_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = TOL_W;

  localparam logic [SCALE_W-1:0] KEY_SCALE = 9'd442;
  localparam logic [TOL_W-1:0]   TOL_RESET = 13'd4096;
  localparam logic [LIM_W-1:0]   LIM_RESET = LIM_W'(TOL_RESET) * LIM_W'(KEY_SCALE);
  localparam logic [Q_W-1:0]     MASK_FULL = 8'hFF;
  localparam logic [Q_W-1:0]     MASK_NONE = 8'h00;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_GREEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BLUE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 2'd3;

  // flags that travel alongside each pixel through the pipeline
  typedef struct packed {
    logic frame_end;
    logic exact;
    logic outside;
  } sb_t;

  typedef struct packed {
    logic [Q_W-1:0] mask_value;
    logic           frame_end;
  } res_t;

endpackage

// File: design/cdk_pixel_if.sv
// pixel channel: valid/ready handshake with rgb payload and end-of-frame mark
// depends on cdk_pkg
`timescale 1ns / 1ps

interface cdk_pixel_if;
  logic                     valid;
  logic                     ready;
  logic [cdk_pkg::CH_W-1:0] pixel_red;
  logic [cdk_pkg::CH_W-1:0] pixel_green;
  logic [cdk_pkg::CH_W-1:0] pixel_blue;
  logic                     frame_end_in;

  modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
                  output frame_end_in, input ready);
  modport sink (input valid, input pixel_red, input pixel_green, input pixel_blue,
                input frame_end_in, output ready);
endinterface

// File: design/cdk_mask_if.sv
// mask channel: valid/ready handshake with mask byte and end-of-frame mark
// depends on cdk_pkg
`timescale 1ns / 1ps

interface cdk_mask_if;
  logic                    valid;
  logic                    ready;
  logic [cdk_pkg::Q_W-1:0] mask_value;
  logic                    frame_end_out;

  modport source (output valid, output mask_value, output frame_end_out, input ready);
  modport sink (input valid, input mask_value, input frame_end_out, output ready);
endinterface

// File: design/color_distance_key_mask.sv
// chroma-key mask from the rgb distance to a key color, one pixel per clock while not stalled
// throughput: one pixel per cycle unless stalled; the 17-stage square root and 8-stage divider set depth
// a two-entry output skid keeps in_px.ready registered; a stall halts the whole pipe
// reset: key color 0,0,0, tolerance 1.0, pipeline and output empty
// depends on cdk_pkg, cdk_pixel_if, cdk_mask_if, cdk_isqrt, cdk_frac_div
`timescale 1ns / 1ps

module color_distance_key_mask (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [cdk_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [cdk_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  cdk_pixel_if.sink                        in_px,
  cdk_mask_if.source                       out_mk
);

  // configuration
  logic [cdk_pkg::CH_W-1:0]  tgt_red_r;
  logic [cdk_pkg::CH_W-1:0]  tgt_green_r;
  logic [cdk_pkg::CH_W-1:0]  tgt_blue_r;
  logic [cdk_pkg::LIM_W-1:0] lim_r;
  logic                      tol_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_red_r   <= '0;
      tgt_green_r <= '0;
      tgt_blue_r  <= '0;
      lim_r       <= cdk_pkg::LIM_RESET;
      tol_zero_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        cdk_pkg::CFG_TARGET_RED:   tgt_red_r   <= cfg_wdata[cdk_pkg::CH_W-1:0];
        cdk_pkg::CFG_TARGET_GREEN: tgt_green_r <= cfg_wdata[cdk_pkg::CH_W-1:0];
        cdk_pkg::CFG_TARGET_BLUE:  tgt_blue_r  <= cfg_wdata[cdk_pkg::CH_W-1:0];
        cdk_pkg::CFG_TOLERANCE: begin
          lim_r      <= cdk_pkg::LIM_W'(cfg_wdata) * cdk_pkg::LIM_W'(cdk_pkg::KEY_SCALE);
          tol_zero_r <= (cfg_wdata == '0);
        end
        default: ;
      endcase
    end
  end

  // global advance, held while the output skid is occupied
  logic en;
  logic sk_valid_r;

  assign en          = !sk_valid_r;
  assign in_px.ready = en;

  // stage 1: channel differences
  logic                            v1_r;
  logic signed [cdk_pkg::DIFF_W-1:0] dr_r, dg_r, db_r;
  logic                            fe1_r;

  // stage 2: squares
  logic                            v2_r;
  logic [cdk_pkg::SQ_W-1:0]        sqr_r, sqg_r, sqb_r;
  logic                            fe2_r;

  // stage 3: squared distance
  logic                            v3_r;
  logic [cdk_pkg::D2_W-1:0]        d2_r;
  cdk_pkg::sb_t                    sb3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_px.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dr_r  <= $signed({1'b0, in_px.pixel_red})   - $signed({1'b0, tgt_red_r});
      dg_r  <= $signed({1'b0, in_px.pixel_green}) - $signed({1'b0, tgt_green_r});
      db_r  <= $signed({1'b0, in_px.pixel_blue})  - $signed({1'b0, tgt_blue_r});
      fe1_r <= in_px.frame_end_in;

      sqr_r <= cdk_pkg::SQ_W'(cdk_pkg::D2_W'(dr_r) * cdk_pkg::D2_W'(dr_r));
      sqg_r <= cdk_pkg::SQ_W'(cdk_pkg::D2_W'(dg_r) * cdk_pkg::D2_W'(dg_r));
      sqb_r <= cdk_pkg::SQ_W'(cdk_pkg::D2_W'(db_r) * cdk_pkg::D2_W'(db_r));
      fe2_r <= fe1_r;

      d2_r  <= cdk_pkg::D2_W'(sqr_r) + cdk_pkg::D2_W'(sqg_r) + cdk_pkg::D2_W'(sqb_r);
      sb3_r <= '{frame_end: fe2_r,
                 exact:     (sqr_r == '0) && (sqg_r == '0) && (sqb_r == '0),
                 outside:   1'b0};
    end
  end

  // distance in q8
  logic                          sq_valid;
  logic [cdk_pkg::ROOT_W-1:0]    sq_root;
  cdk_pkg::sb_t                  sq_sb;

  cdk_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_rad    ({d2_r, cdk_pkg::FRAC_W'(0)}),
    .in_sb     (sb3_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_sb    (sq_sb)
  );

  // stage 4: margin below the limit
  logic                        v4_r;
  logic [cdk_pkg::LIM_W-1:0]   margin_r;
  cdk_pkg::sb_t                sb4_r;
  logic [cdk_pkg::DIST_W-1:0]  dist_q12;
  logic                        outside;

  assign dist_q12 = {sq_root, 4'b0000};
  assign outside  = (cdk_pkg::LIM_W'(dist_q12) >= lim_r);

  // stage 5: margin times 255
  logic                        v5_r;
  logic [cdk_pkg::NUM_W-1:0]   num_r;
  cdk_pkg::sb_t                sb5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v4_r <= sq_valid;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      margin_r <= outside ? '0 : (lim_r - cdk_pkg::LIM_W'(dist_q12));
      sb4_r    <= '{frame_end: sq_sb.frame_end, exact: sq_sb.exact, outside: outside};

      num_r <= (cdk_pkg::NUM_W'(margin_r) << 8) - cdk_pkg::NUM_W'(margin_r);
      sb5_r <= sb4_r;
    end
  end

  logic                      dv_valid;
  logic [cdk_pkg::Q_W-1:0]   dv_quo;
  cdk_pkg::sb_t              dv_sb;

  cdk_frac_div u_frac_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .in_num    (num_r),
    .den       (lim_r),
    .in_sb     (sb5_r),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_sb    (dv_sb)
  );

  // final select
  cdk_pkg::res_t res;

  always_comb begin
    res.frame_end = dv_sb.frame_end;
    if (tol_zero_r) begin
      res.mask_value = dv_sb.exact ? cdk_pkg::MASK_FULL : cdk_pkg::MASK_NONE;
    end else if (dv_sb.outside) begin
      res.mask_value = cdk_pkg::MASK_NONE;
    end else begin
      res.mask_value = dv_quo;
    end
  end

  // output register with skid entry
  logic          out_valid_r;
  cdk_pkg::res_t out_r;
  cdk_pkg::res_t sk_r;
  logic          push;
  logic          pop;

  assign push = en && dv_valid;
  assign pop  = out_valid_r && out_mk.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (sk_valid_r) begin
        out_valid_r <= 1'b1;
        sk_valid_r  <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      sk_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      out_r <= sk_valid_r ? sk_r : res;
    end
    if (push && out_valid_r && !pop) begin
      sk_r <= res;
    end
  end

  assign out_mk.valid         = out_valid_r;
  assign out_mk.mask_value    = out_r.mask_value;
  assign out_mk.frame_end_out = out_r.frame_end;

endmodule

// File: design/cdk_isqrt.sv
// pipelined integer square root, one result bit per stage
// depends on cdk_pkg
`timescale 1ns / 1ps

module cdk_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [cdk_pkg::RAD_W-1:0]    in_rad,
  input  cdk_pkg::sb_t                 in_sb,
  output logic                         out_valid,
  output logic [cdk_pkg::ROOT_W-1:0]   out_root,
  output cdk_pkg::sb_t                 out_sb
);

  localparam int N = cdk_pkg::SQRT_STAGES;

  logic                        vld_r [N];
  logic [cdk_pkg::RAD_W-1:0]   rem_r [N];
  logic [cdk_pkg::RES_W-1:0]   res_r [N];
  cdk_pkg::sb_t                sb_r  [N];

  logic                        vld_in [N];
  logic [cdk_pkg::RAD_W-1:0]   rem_in [N];
  logic [cdk_pkg::RES_W-1:0]   res_in [N];
  cdk_pkg::sb_t                sb_in  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [cdk_pkg::RES_W-1:0] BIT_K =
      cdk_pkg::RES_W'(1) << (cdk_pkg::RAD_W - 2 - 2 * k);

    logic [cdk_pkg::RES_W-1:0] trial;
    logic [cdk_pkg::RAD_W-1:0] rem_nxt;
    logic [cdk_pkg::RES_W-1:0] res_nxt;

    if (k == 0) begin : g_first
      assign vld_in[k] = in_valid;
      assign rem_in[k] = in_rad;
      assign res_in[k] = '0;
      assign sb_in[k]  = in_sb;
    end else begin : g_next
      assign vld_in[k] = vld_r[k-1];
      assign rem_in[k] = rem_r[k-1];
      assign res_in[k] = res_r[k-1];
      assign sb_in[k]  = sb_r[k-1];
    end

    always_comb begin
      trial = res_in[k] + BIT_K;
      if ({1'b0, rem_in[k]} >= trial) begin
        rem_nxt = rem_in[k] - cdk_pkg::RAD_W'(trial);
        res_nxt = (res_in[k] >> 1) + BIT_K;
      end else begin
        rem_nxt = rem_in[k];
        res_nxt = res_in[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        res_r[k] <= res_nxt;
        sb_r[k]  <= sb_in[k];
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_root  = res_r[N-1][cdk_pkg::ROOT_W-1:0];
  assign out_sb    = sb_r[N-1];

endmodule

// File: design/cdk_frac_div.sv
// pipelined restoring divider for an 8-bit quotient, one quotient bit per stage
// depends on cdk_pkg; the user must keep the divisor static while items are in flight, the block does not enforce it
`timescale 1ns / 1ps

module cdk_frac_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [cdk_pkg::NUM_W-1:0]   in_num,
  input  logic [cdk_pkg::LIM_W-1:0]   den,
  input  cdk_pkg::sb_t                in_sb,
  output logic                        out_valid,
  output logic [cdk_pkg::Q_W-1:0]     out_quo,
  output cdk_pkg::sb_t                out_sb
);

  localparam int N = cdk_pkg::DIV_STAGES;

  logic                        vld_r [N];
  logic [cdk_pkg::NUM_W-1:0]   rem_r [N];
  logic [cdk_pkg::Q_W-1:0]     quo_r [N];
  cdk_pkg::sb_t                sb_r  [N];

  logic                        vld_in [N];
  logic [cdk_pkg::NUM_W-1:0]   rem_in [N];
  logic [cdk_pkg::Q_W-1:0]     quo_in [N];
  cdk_pkg::sb_t                sb_in  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int SH = N - 1 - k;

    logic [cdk_pkg::NUM_W-1:0] shifted;
    logic [cdk_pkg::NUM_W-1:0] rem_nxt;
    logic [cdk_pkg::Q_W-1:0]   quo_nxt;

    if (k == 0) begin : g_first
      assign vld_in[k] = in_valid;
      assign rem_in[k] = in_num;
      assign quo_in[k] = '0;
      assign sb_in[k]  = in_sb;
    end else begin : g_next
      assign vld_in[k] = vld_r[k-1];
      assign rem_in[k] = rem_r[k-1];
      assign quo_in[k] = quo_r[k-1];
      assign sb_in[k]  = sb_r[k-1];
    end

    always_comb begin
      shifted = cdk_pkg::NUM_W'(den) << SH;
      rem_nxt = rem_in[k];
      quo_nxt = quo_in[k];
      if (rem_in[k] >= shifted) begin
        rem_nxt     = rem_in[k] - shifted;
        quo_nxt[SH] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        quo_r[k] <= quo_nxt;
        sb_r[k]  <= sb_in[k];
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_quo   = quo_r[N-1];
  assign out_sb    = sb_r[N-1];

endmodule

// File: test/tb_color_distance_key_mask.sv
// testbench for color_distance_key_mask: random rgb pixels against several key settings,
// with a scoreboard class that predicts every mask byte and checks each output transfer
// depends on cdk_pkg, cdk_pixel_if, cdk_mask_if and the color_distance_key_mask rtl
`timescale 1ns / 1ps

module tb_color_distance_key_mask;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int HOLD_CYCLES   = 250;
  localparam int SETTLE_CYCLES = 40;
  localparam int RAND_PHASES   = 12;
  localparam int PHASE_ITEMS   = 105;

  class key_scoreboard;
    logic [cdk_pkg::CH_W-1:0]  key_r;
    logic [cdk_pkg::CH_W-1:0]  key_g;
    logic [cdk_pkg::CH_W-1:0]  key_b;
    logic [cdk_pkg::TOL_W-1:0] tol;
    cdk_pkg::res_t             mask_q[$];
    int                        errors;
    int                        checked;
    int                        full_masks;
    int                        partial_masks;
    int                        zero_masks;

    function new();
      key_r = '0;
      key_g = '0;
      key_b = '0;
      tol = cdk_pkg::TOL_RESET;
    endfunction

    function void set_register(logic [cdk_pkg::CFG_IDX_W-1:0] idx,
                               logic [cdk_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        cdk_pkg::CFG_TARGET_RED:   key_r = data[cdk_pkg::CH_W-1:0];
        cdk_pkg::CFG_TARGET_GREEN: key_g = data[cdk_pkg::CH_W-1:0];
        cdk_pkg::CFG_TARGET_BLUE:  key_b = data[cdk_pkg::CH_W-1:0];
        cdk_pkg::CFG_TOLERANCE:    tol = data[cdk_pkg::TOL_W-1:0];
        default: ;
      endcase
    endfunction

    // floor square root, one result bit at a time from the top
    function longint unsigned floor_root(longint unsigned v);
      longint unsigned r;
      longint unsigned cand;
      r = 0;
      for (int i = 18; i >= 0; i--) begin
        cand = r | (64'd1 << i);
        if (cand * cand <= v) r = cand;
      end
      return r;
    endfunction

    function void note_pixel(logic [cdk_pkg::CH_W-1:0] r, logic [cdk_pkg::CH_W-1:0] g,
                             logic [cdk_pkg::CH_W-1:0] b, logic fe);
      int              dr;
      int              dg;
      int              db;
      longint unsigned dist_sq;
      longint unsigned dist_q8;
      longint unsigned limit_q12;
      longint unsigned scaled;
      cdk_pkg::res_t   res;
      dr = int'(r) - int'(key_r);
      dg = int'(g) - int'(key_g);
      db = int'(b) - int'(key_b);
      dist_sq = longint'(dr * dr + dg * dg + db * db);
      dist_q8 = floor_root(dist_sq << 16);
      limit_q12 = longint'(tol) * longint'(cdk_pkg::KEY_SCALE);
      scaled = dist_q8 * 16;
      if (limit_q12 == 0)
        res.mask_value = (dist_sq == 0) ? cdk_pkg::MASK_FULL : cdk_pkg::MASK_NONE;
      else if (scaled < limit_q12)
        res.mask_value = cdk_pkg::Q_W'((255 * (limit_q12 - scaled)) / limit_q12);
      else
        res.mask_value = cdk_pkg::MASK_NONE;
      res.frame_end = fe;
      mask_q.push_back(res);
    endfunction

    function void check_mask(logic [cdk_pkg::Q_W-1:0] mask, logic fe);
      cdk_pkg::res_t want;
      if (mask_q.size() == 0) begin
        $error("unexpected transfer: mask_value %0d frame_end_out %0b", mask, fe);
        errors++;
        return;
      end
      want = mask_q.pop_front();
      checked++;
      if (mask !== want.mask_value) begin
        $error("mask_value mismatch: expected %0d, actual %0d", want.mask_value, mask);
        errors++;
      end
      if (fe !== want.frame_end) begin
        $error("frame_end_out mismatch: expected %0b, actual %0b", want.frame_end, fe);
        errors++;
      end
      if (want.mask_value == cdk_pkg::MASK_FULL) full_masks++;
      else if (want.mask_value == cdk_pkg::MASK_NONE) zero_masks++;
      else partial_masks++;
    endfunction

    function int pending();
      return mask_q.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [cdk_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [cdk_pkg::CFG_DATA_W-1:0] cfg_wdata;

  cdk_pixel_if in_px();
  cdk_mask_if  out_mk();

  key_scoreboard sb;
  int            cycle_count;
  int            settings_used;
  bit            tx_gapless;
  bit            rx_gapless;
  bit            hold_req;

  color_distance_key_mask u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_px     (in_px),
    .out_mk    (out_mk)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  function automatic int draw_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic logic [cdk_pkg::CH_W-1:0] near(logic [cdk_pkg::CH_W-1:0] c, int spread);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return cdk_pkg::CH_W'(v);
  endfunction

  task automatic send_pixel(input logic [cdk_pkg::CH_W-1:0] r,
                            input logic [cdk_pkg::CH_W-1:0] g,
                            input logic [cdk_pkg::CH_W-1:0] b, input logic fe);
    int gap;
    gap = tx_gapless ? 0 : draw_gap();
    if (gap > 0) begin
      in_px.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_px.valid        <= 1'b1;
    in_px.pixel_red    <= r;
    in_px.pixel_green  <= g;
    in_px.pixel_blue   <= b;
    in_px.frame_end_in <= fe;
    do @(posedge clk); while (!in_px.ready);
    sb.note_pixel(r, g, b, fe);
  endtask

  // stop offering and wait until every mask byte of the burst has come back
  task automatic drain();
    in_px.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cdk_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cdk_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  task automatic program_key(input logic [cdk_pkg::CFG_DATA_W-1:0] r,
                             input logic [cdk_pkg::CFG_DATA_W-1:0] g,
                             input logic [cdk_pkg::CFG_DATA_W-1:0] b,
                             input logic [cdk_pkg::CFG_DATA_W-1:0] t);
    write_reg(cdk_pkg::CFG_TARGET_RED, r);
    write_reg(cdk_pkg::CFG_TARGET_GREEN, g);
    write_reg(cdk_pkg::CFG_TARGET_BLUE, b);
    write_reg(cdk_pkg::CFG_TOLERANCE, t);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic random_pixel();
    logic [cdk_pkg::CH_W-1:0] r;
    logic [cdk_pkg::CH_W-1:0] g;
    logic [cdk_pkg::CH_W-1:0] b;
    int                       spread;
    int                       kind;
    kind = $urandom_range(0, 9);
    case ($urandom_range(0, 4))
      0: spread = 1;
      1: spread = 3;
      2: spread = 12;
      3: spread = 40;
      default: spread = 100;
    endcase
    if (kind == 0) begin
      r = sb.key_r;
      g = sb.key_g;
      b = sb.key_b;
    end else if (kind <= 5) begin
      r = near(sb.key_r, spread);
      g = near(sb.key_g, spread);
      b = near(sb.key_b, spread);
    end else begin
      r = cdk_pkg::CH_W'($urandom);
      g = cdk_pkg::CH_W'($urandom);
      b = cdk_pkg::CH_W'($urandom);
    end
    send_pixel(r, g, b, ($urandom_range(0, 7) == 0));
  endtask

  // receiver: random hold-offs per result, one long hold on request
  initial begin
    int gap;
    out_mk.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = rx_gapless ? 0 : draw_gap();
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_mk.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_mk.ready <= 1'b1;
      do @(posedge clk); while (!out_mk.valid);
      sb.check_mask(out_mk.mask_value, out_mk.frame_end_out);
    end
  end

  initial begin
    logic [cdk_pkg::CFG_DATA_W-1:0] t;
    sb = new();
    settings_used = 1;
    tx_gapless    = 1'b0;
    rx_gapless    = 1'b0;
    hold_req      = 1'b0;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= cdk_pkg::CFG_TARGET_RED;
    cfg_wdata          <= '0;
    in_px.valid        <= 1'b0;
    in_px.pixel_red    <= '0;
    in_px.pixel_green  <= '0;
    in_px.pixel_blue   <= '0;
    in_px.frame_end_in <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key: black, tolerance 1.0
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd1, 8'd0, 8'd0, 1'b0);
    drain();

    // zero tolerance, key written with excess upper bits
    program_key(13'h1FFF, 13'h1F00, 13'h0A80, 13'd0);
    send_pixel(8'd255, 8'd0, 8'd128, 1'b1);
    send_pixel(8'd254, 8'd0, 8'd128, 1'b0);
    send_pixel(8'd255, 8'd1, 8'd128, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd129, 1'b1);
    send_pixel(8'd0, 8'd255, 8'd127, 1'b0);
    drain();

    // largest tolerance, mid gray key
    program_key(13'd128, 13'd128, 13'd128, 13'd8191);
    send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
    send_pixel(8'd127, 8'd129, 8'd128, 1'b0);
    drain();

    // smallest nonzero tolerance, white key
    program_key(13'd255, 13'd255, 13'd255, 13'd1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd254, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0: t = '0;
        1: t = 13'd8191;
        2: t = cdk_pkg::CFG_DATA_W'($urandom_range(1, 64));
        3: t = cdk_pkg::CFG_DATA_W'($urandom_range(0, 8191));
        4: t = cdk_pkg::TOL_RESET;
        default: t = cdk_pkg::CFG_DATA_W'($urandom_range(200, 1500));
      endcase
      program_key(cdk_pkg::CFG_DATA_W'($urandom), cdk_pkg::CFG_DATA_W'($urandom),
                  cdk_pkg::CFG_DATA_W'($urandom), t);
      tx_gapless = (p == 4 || p == 8);
      rx_gapless = (p == 8);
      if (p == 4) hold_req = 1'b1;
      repeat (PHASE_ITEMS) random_pixel();
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("checked %0d mask transfers over %0d key settings", sb.checked, settings_used);
    $display("full masks %0d, partial %0d, zero %0d, errors %0d",
             sb.full_masks, sb.partial_masks, sb.zero_masks, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
